// ----- design/usf_pkg.sv -----
`default_nettype none
package usf_pkg;

   localparam int unsigned POS_WIDTH = 16;
   localparam int unsigned LEN_WIDTH = 17;
   localparam logic [POS_WIDTH-1:0] POS_LAST = '1;

   localparam logic [1:0] SEP_NONE   = 2'd0;
   localparam logic [1:0] SEP_COLON  = 2'd1;
   localparam logic [1:0] SEP_SLASH  = 2'd2;
   localparam logic [1:0] SEP_FULL   = 2'd3;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef struct packed {
      logic letter;
      logic url_char;
      logic colon;
      logic slash;
   } char_class_type;

   typedef struct packed {
      logic                 hit;
      logic [POS_WIDTH-1:0] start;
      logic [LEN_WIDTH-1:0] length;
   } scan_result_type;

endpackage
`default_nettype wire

// ----- design/usf_if.sv -----
`default_nettype none
interface usf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface usf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] url_start;
   logic [16:0] url_length;

   modport source (output valid, output url_start, output url_length, input ready);
   modport sink   (input valid, input url_start, input url_length, output ready);
endinterface
`default_nettype wire

// ----- design/url_span_finder.sv -----
// URL span finder.
// req_bus carries one character of text per item (text_byte) and a flag on
// the final character (end_of_text). rsp_bus carries one item per URL found:
// url_start is the position of the first scheme letter, url_length the number
// of characters. A URL is reported on the character that ends it: a non-URL
// character (not counted) or the flagged final character (counted).
// Both channels move an item at a clock edge where valid and ready are high.
// Throughput: one character per cycle while rsp_bus does not stall. A character
// is held in the input register, then its result (if any) stands in the output
// register, from where rsp_bus can take it.
// The input register and output register form a two-deep path:
// while rsp_bus stalls, one more character is still taken, then req_bus
// ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers and clears the
// scan state; the next character starts a new string at position 0. After the
// flagged final character the scan state returns to the same reset values.
`default_nettype none
module url_span_finder (
   input  wire logic  clock,
   input  wire logic  reset,
   usf_req_if.sink    req_bus,
   usf_rsp_if.source  rsp_bus
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       out_valid_ff, out_valid_in;
   logic [usf_pkg::POS_WIDTH-1:0] out_start_ff;
   logic [usf_pkg::LEN_WIDTH-1:0] out_length_ff;

   logic out_free;
   logic s1_fire;
   logic req_take;

   usf_pkg::char_class_type  char_class;
   usf_pkg::scan_result_type result;

   usf_class u_class (
      .text_byte  (s1_byte_ff),
      .char_class (char_class)
   );

   usf_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_fire),
      .char_class  (char_class),
      .end_of_text (s1_last_ff),
      .result      (result)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (s1_fire) begin
         out_valid_in = result.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_bus.text_byte;
         s1_last_ff <= req_bus.end_of_text;
      end
      if (s1_fire && result.hit) begin
         out_start_ff  <= result.start;
         out_length_ff <= result.length;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.url_start  = out_start_ff;
   assign rsp_bus.url_length = out_length_ff;

endmodule
`default_nettype wire

// ----- design/usf_class.sv -----
`default_nettype none
module usf_class (
   input  wire logic [7:0]             text_byte,
   output usf_pkg::char_class_type     char_class
);

   always_comb begin
      char_class.letter   = 1'b0;
      char_class.url_char = 1'b0;
      char_class.colon    = (text_byte == usf_pkg::CHAR_COLON);
      char_class.slash    = (text_byte == usf_pkg::CHAR_SLASH);
      unique case (text_byte) inside
         [8'h41:8'h5A], [8'h61:8'h7A]: begin
            char_class.letter   = 1'b1;
            char_class.url_char = 1'b1;
         end
         [8'h30:8'h39], 8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26, 8'h24,
         8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h2C: begin
            char_class.url_char = 1'b1;
         end
         default: begin
            char_class.url_char = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/usf_scan.sv -----
`default_nettype none
module usf_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire usf_pkg::char_class_type char_class,
   input  wire logic                    end_of_text,
   output usf_pkg::scan_result_type     result
);

   logic [usf_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [usf_pkg::POS_WIDTH-1:0] run_start_ff, run_start_in;
   logic                          prev_letter_ff, prev_letter_in;
   logic [1:0]                    sep_ff, sep_in;
   logic [usf_pkg::POS_WIDTH-1:0] scheme_start_ff, scheme_start_in;
   logic                          scheme_present_ff, scheme_present_in;
   logic                          inside_ff, inside_in;
   logic [usf_pkg::POS_WIDTH-1:0] url_start_ff, url_start_in;

   logic                          span_hit;
   logic [usf_pkg::POS_WIDTH-1:0] span_start;
   logic                          span_incl;
   logic [usf_pkg::LEN_WIDTH-1:0] span_len;

   always_comb begin
      pos_in            = pos_ff;
      run_start_in      = run_start_ff;
      prev_letter_in    = prev_letter_ff;
      sep_in            = sep_ff;
      scheme_start_in   = scheme_start_ff;
      scheme_present_in = scheme_present_ff;
      inside_in         = inside_ff;
      url_start_in      = url_start_ff;
      span_hit          = 1'b0;
      span_start        = url_start_ff;
      span_incl         = 1'b1;

      if (inside_ff) begin
         if (!char_class.url_char) begin
            span_hit   = 1'b1;
            span_incl  = 1'b0;
            inside_in  = 1'b0;
         end else if (end_of_text) begin
            span_hit = 1'b1;
         end
         sep_in         = usf_pkg::SEP_NONE;
         prev_letter_in = char_class.letter;
      end else if (sep_ff == usf_pkg::SEP_FULL && scheme_present_ff && char_class.url_char) begin
         inside_in      = 1'b1;
         url_start_in   = scheme_start_ff;
         span_start     = scheme_start_ff;
         span_hit       = end_of_text;
         sep_in         = usf_pkg::SEP_NONE;
         prev_letter_in = char_class.letter;
      end else begin
         if (char_class.colon) begin
            sep_in            = usf_pkg::SEP_COLON;
            scheme_present_in = prev_letter_ff;
            scheme_start_in   = run_start_ff;
         end else if (char_class.slash && sep_ff == usf_pkg::SEP_COLON) begin
            sep_in = usf_pkg::SEP_SLASH;
         end else if (char_class.slash && sep_ff == usf_pkg::SEP_SLASH) begin
            sep_in = usf_pkg::SEP_FULL;
         end else begin
            sep_in = usf_pkg::SEP_NONE;
         end
         if (char_class.letter && !prev_letter_ff) begin
            run_start_in = pos_ff;
         end
         prev_letter_in = char_class.letter;
      end

      if (pos_ff != usf_pkg::POS_LAST) begin
         pos_in = pos_ff + 1'b1;
      end

      if (end_of_text) begin
         pos_in            = '0;
         run_start_in      = '0;
         prev_letter_in    = 1'b0;
         sep_in            = usf_pkg::SEP_NONE;
         scheme_start_in   = '0;
         scheme_present_in = 1'b0;
         inside_in         = 1'b0;
         url_start_in      = '0;
      end
   end

   assign span_len = {1'b0, pos_ff} - {1'b0, span_start}
                     + {{(usf_pkg::LEN_WIDTH-1){1'b0}}, span_incl};

   always_comb begin
      result.hit    = span_hit;
      result.start  = span_start;
      result.length = span_len;
      if (span_len == '0) begin
         result.length = {{(usf_pkg::LEN_WIDTH-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff            <= '0;
         run_start_ff      <= '0;
         prev_letter_ff    <= 1'b0;
         sep_ff            <= usf_pkg::SEP_NONE;
         scheme_start_ff   <= '0;
         scheme_present_ff <= 1'b0;
         inside_ff         <= 1'b0;
         url_start_ff      <= '0;
      end else if (step) begin
         pos_ff            <= pos_in;
         run_start_ff      <= run_start_in;
         prev_letter_ff    <= prev_letter_in;
         sep_ff            <= sep_in;
         scheme_start_ff   <= scheme_start_in;
         scheme_present_ff <= scheme_present_in;
         inside_ff         <= inside_in;
         url_start_ff      <= url_start_in;
      end
   end

endmodule
`default_nettype wire

// ----- test/url_span_finder_checker.sv -----
`timescale 1ns / 100ps
module url_span_finder_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_end_of_text,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [usf_pkg::POS_WIDTH-1:0] rsp_url_start,
   input  logic [usf_pkg::LEN_WIDTH-1:0] rsp_url_length,
   output int                            fail_count,
   output int                            open_count
);

   localparam logic [8*19-1:0] URL_MARKS = "~;/?:@=&$-_.+!*'(),";

   typedef struct packed {
      logic [usf_pkg::POS_WIDTH-1:0] start;
      logic [usf_pkg::LEN_WIDTH-1:0] length;
   } url_span_type;

   url_span_type url_spans_due[$];

   logic [usf_pkg::POS_WIDTH-1:0] scan_pos;
   logic [usf_pkg::POS_WIDTH-1:0] run_start;
   logic                          last_was_letter;
   logic [1:0]                    sep_stage;
   logic [usf_pkg::POS_WIDTH-1:0] scheme_pos;
   logic                          scheme_ok;
   logic                          in_url;
   logic [usf_pkg::POS_WIDTH-1:0] url_origin;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_url_byte(input logic [7:0] c);
      if (is_alpha(c) || (c >= "0" && c <= "9")) begin
         return 1'b1;
      end
      for (int k = 0; k < 19; k++) begin
         if (URL_MARKS[8*k +: 8] == c) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic clear_scan();
      scan_pos        = '0;
      run_start       = '0;
      last_was_letter = 1'b0;
      sep_stage       = usf_pkg::SEP_NONE;
      scheme_pos      = '0;
      scheme_ok       = 1'b0;
      in_url          = 1'b0;
      url_origin      = '0;
   endtask

   // span = end - origin (+1 when the end character belongs to the URL), at least 1
   task automatic record_url(input logic inclusive);
      url_span_type span;
      span.start  = url_origin;
      span.length = {1'b0, scan_pos} - {1'b0, url_origin}
                    + usf_pkg::LEN_WIDTH'(inclusive);
      if (span.length == '0) begin
         span.length = {{(usf_pkg::LEN_WIDTH-1){1'b0}}, 1'b1};
      end
      url_spans_due = {url_spans_due, span};
   endtask

   task automatic scan_char(input logic [7:0] c, input logic eot);
      logic letter;
      logic urlc;
      letter = is_alpha(c);
      urlc   = is_url_byte(c);
      if (in_url) begin
         if (!urlc) begin
            record_url(1'b0);
            in_url = 1'b0;
         end else if (eot) begin
            record_url(1'b1);
         end
         sep_stage       = usf_pkg::SEP_NONE;
         last_was_letter = letter;
      end else if (sep_stage == usf_pkg::SEP_FULL && scheme_ok && urlc) begin
         in_url     = 1'b1;
         url_origin = scheme_pos;
         if (eot) begin
            record_url(1'b1);
         end
         sep_stage       = usf_pkg::SEP_NONE;
         last_was_letter = letter;
      end else begin
         if (c == usf_pkg::CHAR_COLON) begin
            sep_stage  = usf_pkg::SEP_COLON;
            scheme_ok  = last_was_letter;
            scheme_pos = run_start;
         end else if (c == usf_pkg::CHAR_SLASH && sep_stage == usf_pkg::SEP_COLON) begin
            sep_stage = usf_pkg::SEP_SLASH;
         end else if (c == usf_pkg::CHAR_SLASH && sep_stage == usf_pkg::SEP_SLASH) begin
            sep_stage = usf_pkg::SEP_FULL;
         end else begin
            sep_stage = usf_pkg::SEP_NONE;
         end
         if (letter && !last_was_letter) begin
            run_start = scan_pos;
         end
         last_was_letter = letter;
      end
      if (scan_pos != usf_pkg::POS_LAST) begin
         scan_pos = scan_pos + 1'b1;
      end
      if (eot) begin
         clear_scan();
      end
   endtask

   always @(posedge clock) begin
      url_span_type due;
      if (reset) begin
         clear_scan();
         url_spans_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (url_spans_due.size() == 0) begin
               $error("unexpected URL item: url_start %0d, url_length %0d",
                      rsp_url_start, rsp_url_length);
               fail_count++;
            end else begin
               due = url_spans_due.pop_front();
               if (rsp_url_start !== due.start) begin
                  $error("url_start mismatch: expected %0d, actual %0d",
                         due.start, rsp_url_start);
                  fail_count++;
               end
               if (rsp_url_length !== due.length) begin
                  $error("url_length mismatch: expected %0d, actual %0d",
                         due.length, rsp_url_length);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            scan_char(req_text_byte, req_end_of_text);
         end
      end
      open_count = url_spans_due.size();
   end

endmodule

// ----- test/url_span_finder_tb.sv -----
`timescale 1ns / 100ps
module url_span_finder_tb;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [8*19-1:0] URL_MARKS      = "~;/?:@=&$-_.+!*'(),";
   localparam logic [8*14-1:0] NON_URL_CHARS  = " \"<>#%^\t{|}[]\\";

   logic clock;
   logic reset;
   int   fail_count;
   int   open_count;
   int   cycle_count;
   int   sent_items;
   bit   idle_enable;
   bit   hold_off_request;

   logic [7:0] line_buf[$];

   usf_req_if req_bus ();
   usf_rsp_if rsp_bus ();

   url_span_finder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   url_span_finder_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_text_byte   (req_bus.text_byte),
      .req_end_of_text (req_bus.end_of_text),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_url_start   (rsp_bus.url_start),
      .rsp_url_length  (rsp_bus.url_length),
      .fail_count      (fail_count),
      .open_count      (open_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_bus.ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               @(negedge clock);
            end
            hold_off_request = 1'b0;
         end
         rsp_bus.ready <= !(idle_enable && $urandom_range(99) < 9);
      end
   end

   function automatic logic [7:0] pick_letter();
      return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
   endfunction

   function automatic logic [7:0] pick_url_char();
      case ($urandom_range(2))
         0:       return pick_letter();
         1:       return 8'("0" + $urandom_range(9));
         default: return URL_MARKS[8*$urandom_range(18) +: 8];
      endcase
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eot);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= b;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      sent_items++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      line_buf = {line_buf, b};
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++) begin
         send_item(line_buf[i], i == line_buf.size() - 1);
      end
      line_buf.delete();
   endtask

   task automatic append_token();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 40) begin
         n = $urandom_range(1, 4);
         repeat (n) add_byte(pick_letter());
         case ($urandom_range(11))
            0:       push_text(":/");
            1:       push_text(":");
            2:       push_text("//");
            3:       push_text(":/:/");
            default: push_text("://");
         endcase
         n = $urandom_range(0, 10);
         repeat (n) add_byte(pick_url_char());
      end else if (kind < 55) begin
         n = $urandom_range(1, 6);
         repeat (n) add_byte(pick_letter());
      end else if (kind < 65) begin
         case ($urandom_range(3))
            0:       push_text(":");
            1:       push_text(":/");
            2:       push_text("://");
            default: push_text("/");
         endcase
      end else if (kind < 75) begin
         n = $urandom_range(1, 5);
         repeat (n) add_byte(pick_url_char());
      end else if (kind < 90) begin
         add_byte(NON_URL_CHARS[8*$urandom_range(13) +: 8]);
      end else begin
         add_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int random_base;
      int n;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.text_byte   = '0;
      req_bus.end_of_text = 1'b0;
      idle_enable         = 1'b1;
      hold_off_request    = 1'b0;
      sent_items          = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_text("a://b");
      send_line();
      push_text("://q");
      send_line();
      push_text("A://");
      send_line();
      push_text("z://a://");
      add_byte(8'hFF);
      send_line();
      push_text(" ab://cd ab://e");
      send_line();

      hold_off_request = 1'b1;
      random_base = sent_items;
      while (sent_items - random_base < RANDOM_ITEMS) begin
         idle_enable = !(sent_items - random_base >= 700 && sent_items - random_base < 1100);
         n = $urandom_range(1, 8);
         repeat (n) append_token();
         send_line();
      end
      idle_enable = 1'b1;
      @(negedge clock);
      req_bus.valid <= 1'b0;

      wait (open_count == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
